// ----- rtl/lms_pkg.sv -----
package lms_pkg;

   // Default geometry of the panel.
   localparam int BRIGHTNESS_PHASES_DEF = 32;
   localparam int LED_ROWS_DEF          = 6;
   localparam int SWITCH_ROWS_DEF       = 3;

   // Fixed field widths of the channels.
   localparam int COL_W         = 12;
   localparam int PHASE_IN_W    = 5;
   localparam int ROW_IN_W      = 3;
   localparam int LED_DRIVE_W   = 6;
   localparam int SW_DRIVE_W    = 3;
   localparam int ADDR_KNOB_W   = 3;
   localparam int DATA_KNOB_W   = 2;
   localparam int ENC_W         = 2;
   localparam int SHOWN_SW_ROWS = 3;

   // Item kinds.
   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Knob encoder bit positions within switch row 2.
   localparam int ENC0_LSB = 8;
   localparam int ENC1_LSB = 10;

   // Gray encoder codes.
   localparam logic [ENC_W-1:0] ENC_REST = 2'b11;
   localparam logic [ENC_W-1:0] ENC_CW   = 2'b01;
   localparam logic [ENC_W-1:0] ENC_CCW  = 2'b10;

   // Idle levels of the panel lines.
   localparam logic [COL_W-1:0]      COL_ALL_OFF = '1;
   localparam logic [SW_DRIVE_W-1:0] SW_ALL_OFF  = '1;

endpackage

// ----- rtl/lms_req_if.sv -----
interface lms_req_if;
   import lms_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  action;
   logic                  read_bank;
   logic [COL_W-1:0]      column_sense;
   logic                  write_bank;
   logic [PHASE_IN_W-1:0] write_phase;
   logic [ROW_IN_W-1:0]   write_row;
   logic [COL_W-1:0]      write_bits;

   modport source (
      output valid, action, read_bank, column_sense, write_bank, write_phase,
             write_row, write_bits,
      input  ready
   );

   modport sink (
      input  valid, action, read_bank, column_sense, write_bank, write_phase,
             write_row, write_bits,
      output ready
   );

endinterface

// ----- rtl/lms_rsp_if.sv -----
interface lms_rsp_if;
   import lms_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [LED_DRIVE_W-1:0] led_row_drive;
   logic [COL_W-1:0]       column_drive;
   logic                   columns_input_mode;
   logic [SW_DRIVE_W-1:0]  switch_row_drive;
   logic [COL_W-1:0]       switch_row_a;
   logic [COL_W-1:0]       switch_row_b;
   logic [COL_W-1:0]       switch_row_c;
   logic [ADDR_KNOB_W-1:0] address_knob;
   logic [DATA_KNOB_W-1:0] data_knob;

   modport source (
      output valid, led_row_drive, column_drive, columns_input_mode,
             switch_row_drive, switch_row_a, switch_row_b, switch_row_c,
             address_knob, data_knob,
      input  ready
   );

   modport sink (
      input  valid, led_row_drive, column_drive, columns_input_mode,
             switch_row_drive, switch_row_a, switch_row_b, switch_row_c,
             address_knob, data_knob,
      output ready
   );

endinterface

// ----- rtl/lms_ram.sv -----
module lms_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/led_matrix_switch_scanner.sv -----
// Channel   Dir   Interface    Carries
// req_ch    in    lms_req_if   scan tick or pattern word write
// rsp_ch    out   lms_rsp_if   panel line levels, switch rows, knob counts
//
// One item is accepted per cycle while the output is not stalled; every item gives one result,
// through the registered read of the pattern RAM and then the output register.
// Each item uses at most one pattern RAM port (write or read), which allows one item a cycle.
// Reset clears the slot and phase counters, switch rows, encoders and knobs;
// the pattern RAM is not cleared and must be written before it is displayed.
// With rsp_ch.ready low the result holds and one more item is still taken.
module led_matrix_switch_scanner #(
   parameter int BRIGHTNESS_PHASES = lms_pkg::BRIGHTNESS_PHASES_DEF,
   parameter int LED_ROWS          = lms_pkg::LED_ROWS_DEF,
   parameter int SWITCH_ROWS       = lms_pkg::SWITCH_ROWS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lms_req_if.sink   req_ch,
   lms_rsp_if.source rsp_ch
);
   import lms_pkg::*;

   localparam int SLOTS   = LED_ROWS + SWITCH_ROWS;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int PHASE_W = (BRIGHTNESS_PHASES > 1) ? $clog2(BRIGHTNESS_PHASES) : 1;
   localparam int ROW_W   = (LED_ROWS > 1) ? $clog2(LED_ROWS) : 1;
   localparam int ADDR_W  = 1 + PHASE_W + ROW_W;
   localparam int DEPTH   = 2 ** ADDR_W;

   typedef struct packed {
      logic                   led_slot;
      logic [LED_DRIVE_W-1:0] led_drive;
      logic [COL_W-1:0]       col_drive;
      logic                   in_mode;
      logic [SW_DRIVE_W-1:0]  sw_drive;
   } slot_ctl_type;

   typedef struct packed {
      logic [ENC_W-1:0] last;
      logic             up;
      logic             down;
   } enc_step_type;

   // One detent step of a Gray encoder.
   function automatic enc_step_type enc_decode(logic [ENC_W-1:0] last,
                                               logic [ENC_W-1:0] code);
      enc_step_type res;
      res.last = last;
      res.up   = 1'b0;
      res.down = 1'b0;
      if (last == ENC_REST && (code == ENC_CW || code == ENC_CCW)) begin
         res.last = code;
      end else if (code == ENC_REST && last == ENC_CW) begin
         res.last = ENC_REST;
         res.up   = 1'b1;
      end else if (code == ENC_REST && last == ENC_CCW) begin
         res.last = ENC_REST;
         res.down = 1'b1;
      end
      return res;
   endfunction

   logic                   accept;
   logic                   out_adv;
   logic                   tick;
   logic                   led_slot;
   logic                   cap_row2;
   logic [SLOT_W-1:0]      sw_idx;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [COL_W-1:0]       rd_data;
   enc_step_type           enc0_step;
   enc_step_type           enc1_step;

   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [COL_W-1:0]       sw_row_ff [SHOWN_SW_ROWS];
   logic [ENC_W-1:0]       enc0_ff, enc1_ff;
   logic [ADDR_KNOB_W-1:0] addr_knob_ff;
   logic [DATA_KNOB_W-1:0] data_knob_ff;
   logic                   s1_valid_ff, s1_valid_in;
   slot_ctl_type           s1_ctl_ff, s1_ctl_in;
   logic                   out_valid_ff, out_valid_in;
   logic [LED_DRIVE_W-1:0] out_led_ff;
   logic [COL_W-1:0]       out_col_ff;
   logic                   out_mode_ff;
   logic [SW_DRIVE_W-1:0]  out_sw_ff;
   logic [COL_W-1:0]       out_row_a_ff, out_row_b_ff, out_row_c_ff;
   logic [ADDR_KNOB_W-1:0] out_addr_knob_ff;
   logic [DATA_KNOB_W-1:0] out_data_knob_ff;

   // Handshake: the output register frees the read stage, which frees the input.
   assign out_adv      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || out_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   // Slot decode of the accepted item.
   assign tick     = accept && (req_ch.action == ACTION_TICK);
   assign led_slot = slot_ff < SLOT_W'(LED_ROWS);
   assign sw_idx   = slot_ff - SLOT_W'(LED_ROWS);
   assign cap_row2 = tick && !led_slot && (sw_idx == SLOT_W'(2));

   // Pattern RAM addressing: bank, phase, row.
   always_comb begin
      wr_en   = accept && (req_ch.action == ACTION_WRITE)
                && (int'(req_ch.write_phase) < BRIGHTNESS_PHASES)
                && (int'(req_ch.write_row) < LED_ROWS);
      wr_addr = {req_ch.write_bank, PHASE_W'(req_ch.write_phase), ROW_W'(req_ch.write_row)};
      rd_addr = {req_ch.read_bank, phase_ff, ROW_W'(slot_ff)};
   end

   lms_ram #(
      .WIDTH (COL_W),
      .DEPTH (DEPTH)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.write_bits),
      .rd_en   (tick && led_slot),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next slot and phase.
   always_comb begin
      slot_in  = slot_ff;
      phase_in = phase_ff;
      if (tick) begin
         if (slot_ff == SLOT_W'(SLOTS - 1)) begin
            slot_in = '0;
            if (phase_ff == PHASE_W'(BRIGHTNESS_PHASES - 1)) begin
               phase_in = '0;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   // Encoder steps from the columns of switch row 2.
   assign enc0_step = enc_decode(enc0_ff, req_ch.column_sense[ENC0_LSB +: ENC_W]);
   assign enc1_step = enc_decode(enc1_ff, req_ch.column_sense[ENC1_LSB +: ENC_W]);

   // Line levels of the slot, carried beside the RAM read.
   always_comb begin
      s1_ctl_in.led_slot  = 1'b0;
      s1_ctl_in.led_drive = '0;
      s1_ctl_in.col_drive = COL_ALL_OFF;
      s1_ctl_in.in_mode   = 1'b0;
      s1_ctl_in.sw_drive  = SW_ALL_OFF;
      if (req_ch.action == ACTION_TICK) begin
         if (led_slot) begin
            s1_ctl_in.led_slot  = 1'b1;
            s1_ctl_in.led_drive = LED_DRIVE_W'(1) << slot_ff;
         end else begin
            s1_ctl_in.col_drive = '0;
            s1_ctl_in.in_mode   = 1'b1;
            s1_ctl_in.sw_drive  = ~(SW_DRIVE_W'(1) << sw_idx);
         end
      end
   end

   // Pipeline valid bits.
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (out_adv ? 1'b0 : s1_valid_ff);
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;
   end

   // Scan state, switch rows and knobs.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         phase_ff     <= '0;
         enc0_ff      <= ENC_REST;
         enc1_ff      <= ENC_REST;
         addr_knob_ff <= '0;
         data_knob_ff <= '0;
         for (int i = 0; i < SHOWN_SW_ROWS; i++) begin
            sw_row_ff[i] <= '0;
         end
      end else begin
         slot_ff  <= slot_in;
         phase_ff <= phase_in;
         for (int i = 0; i < SHOWN_SW_ROWS; i++) begin
            if (tick && !led_slot && sw_idx == SLOT_W'(i)) begin
               sw_row_ff[i] <= req_ch.column_sense;
            end
         end
         if (cap_row2) begin
            enc0_ff <= enc0_step.last;
            enc1_ff <= enc1_step.last;
            if (enc0_step.up) begin
               addr_knob_ff <= addr_knob_ff + 1'b1;
            end else if (enc0_step.down) begin
               addr_knob_ff <= addr_knob_ff - 1'b1;
            end
            if (enc1_step.up) begin
               data_knob_ff <= data_knob_ff + 1'b1;
            end else if (enc1_step.down) begin
               data_knob_ff <= data_knob_ff - 1'b1;
            end
         end
      end
   end

   // Read stage and output register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payloads; state registers match the item in the read stage when it moves on.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff <= s1_ctl_in;
      end
      if (out_adv && s1_valid_ff) begin
         out_led_ff       <= s1_ctl_ff.led_drive;
         out_col_ff       <= s1_ctl_ff.led_slot ? ~rd_data : s1_ctl_ff.col_drive;
         out_mode_ff      <= s1_ctl_ff.in_mode;
         out_sw_ff        <= s1_ctl_ff.sw_drive;
         out_row_a_ff     <= sw_row_ff[0];
         out_row_b_ff     <= sw_row_ff[1];
         out_row_c_ff     <= sw_row_ff[2];
         out_addr_knob_ff <= addr_knob_ff;
         out_data_knob_ff <= data_knob_ff;
      end
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.led_row_drive      = out_led_ff;
   assign rsp_ch.column_drive       = out_col_ff;
   assign rsp_ch.columns_input_mode = out_mode_ff;
   assign rsp_ch.switch_row_drive   = out_sw_ff;
   assign rsp_ch.switch_row_a       = out_row_a_ff;
   assign rsp_ch.switch_row_b       = out_row_b_ff;
   assign rsp_ch.switch_row_c       = out_row_c_ff;
   assign rsp_ch.address_knob       = out_addr_knob_ff;
   assign rsp_ch.data_knob          = out_data_knob_ff;

`ifndef NO_ASSERTIONS
   // The slot counter never leaves its range.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < SLOT_W'(SLOTS))
      else $error("scan slot out of range");

   // A tick in an LED slot puts a RAM read into the read stage.
   a_led_read: assert property (@(posedge clock) disable iff (reset)
      tick && led_slot |=> s1_valid_ff && s1_ctl_ff.led_slot)
      else $error("LED slot lost its pattern read");

   // The read stage never holds a new item while it is stalled.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_adv |-> !accept)
      else $error("item accepted over a stalled read stage");

   // A valid result drives LED rows or reads switches, never both.
   a_slot_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0(out_led_ff) && !(out_mode_ff && (out_led_ff != '0)))
      else $error("LED row and switch mode active together");

   // Knob counts move only on a capture of switch row 2; this checks the address knob.
   a_knob_cause: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(addr_knob_ff) |-> $past(cap_row2))
      else $error("address knob moved without a row 2 capture");
`endif

endmodule
